// ===== rtl/address_range_coalescer_top_macros.svh =====
// Assertion macros used by the checker file of the range coalescer.
`ifndef ADDRESS_RANGE_COALESCER_TOP_MACROS_SVH
`define ADDRESS_RANGE_COALESCER_TOP_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ARC_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("lbl failed");
// Implication with the consequent checked in the cycle after the antecedent.
`define ARC_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("lbl failed");
`endif

// ===== rtl/arc_pkg.sv =====
// Package with shared types and constants of the address range coalescer.
package arc_pkg;
  localparam int MaxRanges = 16;
  localparam int AddrWidth = 64;

  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusFull = 2'd1;
  localparam logic [1:0] StatusBad = 2'd2;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_INSERT,
    BK_FLUSH
  } back_state_t;
endpackage

// ===== rtl/arc_front.sv =====
// Front end: accepts commands, checks the range and queues them.
module arc_front #(
  parameter int ADDR_WIDTH = arc_pkg::AddrWidth
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_cmd,
  input  logic [ADDR_WIDTH-1:0] in_first,
  input  logic [ADDR_WIDTH-1:0] in_last,
  output logic                  q_valid,
  input  logic                  q_pop,
  output logic                  q_cmd,
  output logic                  q_bad,
  output logic [ADDR_WIDTH-1:0] q_first,
  output logic [ADDR_WIDTH-1:0] q_last
);
  // Two-entry queue decouples the front from the table logic.
  logic [1:0]                  vld_r, vld_nxt;
  logic [1:0]                  cmd_r;
  logic [1:0]                  bad_r;
  logic [1:0][ADDR_WIDTH-1:0]  first_r;
  logic [1:0][ADDR_WIDTH-1:0]  last_r;
  logic                        push;

  assign in_ready = !vld_r[1];
  assign push = in_valid && in_ready;
  assign q_valid = vld_r[0];
  assign q_cmd = cmd_r[0];
  assign q_bad = bad_r[0];
  assign q_first = first_r[0];
  assign q_last = last_r[0];

  always_comb begin
    vld_nxt = vld_r;
    if (q_pop) begin
      vld_nxt = {1'b0, vld_r[1]};
    end
    if (push) begin
      if (!vld_nxt[0]) begin
        vld_nxt[0] = 1'b1;
      end else begin
        vld_nxt[1] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // A push only happens while the second slot is free, so a pushed command
  // lands in the head slot unless the head stays occupied.
  always_ff @(posedge clk) begin
    if (push && (!vld_r[0] || q_pop)) begin
      cmd_r[0] <= in_cmd;
      bad_r[0] <= in_first > in_last;
      first_r[0] <= in_first;
      last_r[0] <= in_last;
    end else if (q_pop) begin
      cmd_r[0] <= cmd_r[1];
      bad_r[0] <= bad_r[1];
      first_r[0] <= first_r[1];
      last_r[0] <= last_r[1];
    end
    if (push && vld_r[0] && !q_pop) begin
      cmd_r[1] <= in_cmd;
      bad_r[1] <= in_first > in_last;
      first_r[1] <= in_first;
      last_r[1] <= in_last;
    end
  end
endmodule

// ===== rtl/arc_back.sv =====
// Back end: range table cells, merge/insert and ordered flush.
module arc_back #(
  parameter int MAX_RANGES = arc_pkg::MaxRanges,
  parameter int ADDR_WIDTH = arc_pkg::AddrWidth
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  output logic                  q_pop,
  input  logic                  q_cmd,
  input  logic                  q_bad,
  input  logic [ADDR_WIDTH-1:0] q_first,
  input  logic [ADDR_WIDTH-1:0] q_last,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ADDR_WIDTH-1:0] out_begin,
  output logic [ADDR_WIDTH-1:0] out_end,
  output logic [1:0]            out_status,
  output logic [4:0]            out_held,
  output logic                  out_last,
  output logic                  out_none
);
  localparam int CntW = $clog2(MAX_RANGES + 1);
  localparam int IdxW = $clog2(MAX_RANGES);
  localparam logic [ADDR_WIDTH-1:0] TopAddr = '1;

  arc_pkg::back_state_t state_r, state_nxt;

  logic [MAX_RANGES-1:0][ADDR_WIDTH-1:0] st_r, st_nxt;
  logic [MAX_RANGES-1:0][ADDR_WIDTH-1:0] en_r, en_nxt;
  logic [CntW-1:0]                       cnt_r, cnt_nxt;
  logic [CntW-1:0]                       fidx_r, fidx_nxt;

  // Per-cell classification registered in the first insert cycle.
  logic [MAX_RANGES-1:0] tch_c, tch_r;
  logic [MAX_RANGES-1:0] gt_c, gt_r;
  logic                  cov_c, cov_r;
  logic [ADDR_WIDTH-1:0] f_r, l_r;

  logic [MAX_RANGES-1:0] below;
  logic [ADDR_WIDTH-1:0] lo, hi;
  logic [CntW-1:0]       nm;
  logic [CntW-1:0]       pos;
  logic [IdxW-1:0]       tail_idx;

  logic                  ov_r, ov_nxt;
  logic [ADDR_WIDTH-1:0] ob_r, ob_nxt, oe_r, oe_nxt;
  logic [1:0]            os_r, os_nxt;
  logic [4:0]            oh_r, oh_nxt;
  logic                  ol_r, ol_nxt, on_r, on_nxt;
  logic                  ofree;

  assign ofree = !ov_r || out_ready;
  assign out_valid = ov_r;
  assign out_begin = ob_r;
  assign out_end = oe_r;
  assign out_status = os_r;
  assign out_held = oh_r;
  assign out_last = ol_r;
  assign out_none = on_r;

  always_comb begin
    cov_c = 1'b0;
    for (int i = 0; i < MAX_RANGES; i++) begin
      below[i] = i < int'(cnt_r);
      tch_c[i] = below[i] && ((st_r[i] <= q_last && q_first <= en_r[i]) ||
                 (en_r[i] != TopAddr && en_r[i] + 1'b1 == q_first) ||
                 (q_last != TopAddr && q_last + 1'b1 == st_r[i]));
      gt_c[i] = below[i] && st_r[i] > q_last;
      if (below[i] && st_r[i] <= q_first && q_last <= en_r[i]) begin
        cov_c = 1'b1;
      end
    end
  end

  // Merged bounds and new layout from the registered cell flags.
  always_comb begin
    nm = '0;
    pos = '0;
    for (int i = 0; i < MAX_RANGES; i++) begin
      if (tch_r[i]) nm = nm + 1'b1;
      if (i < int'(cnt_r) && !tch_r[i] && !gt_r[i]) pos = pos + 1'b1;
    end
    tail_idx = IdxW'(int'(pos) + int'(nm) - 1);
    lo = f_r;
    hi = l_r;
    // Touching cells are contiguous from pos, so the outer two give the bounds.
    if (nm != '0) begin
      if (st_r[pos[IdxW-1:0]] < f_r) lo = st_r[pos[IdxW-1:0]];
      if (en_r[tail_idx] > l_r) hi = en_r[tail_idx];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      arc_pkg::BK_IDLE: begin
        if (q_valid && ofree) begin
          if (q_cmd && cnt_r != '0) state_nxt = arc_pkg::BK_FLUSH;
          else if (!q_cmd && !q_bad) state_nxt = arc_pkg::BK_INSERT;
        end
      end
      arc_pkg::BK_INSERT: begin
        if (ofree) state_nxt = arc_pkg::BK_IDLE;
      end
      arc_pkg::BK_FLUSH: begin
        if (ofree && fidx_r + 1'b1 == cnt_r) state_nxt = arc_pkg::BK_IDLE;
      end
      default: state_nxt = arc_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop = 1'b0;
    st_nxt = st_r;
    en_nxt = en_r;
    cnt_nxt = cnt_r;
    fidx_nxt = fidx_r;
    ov_nxt = ov_r && !out_ready;
    ob_nxt = ob_r;
    oe_nxt = oe_r;
    os_nxt = os_r;
    oh_nxt = oh_r;
    ol_nxt = ol_r;
    on_nxt = on_r;
    case (state_r)
      arc_pkg::BK_IDLE: begin
        fidx_nxt = '0;
        if (q_valid && ofree) begin
          if (q_cmd) begin
            if (cnt_r == '0) begin
              q_pop = 1'b1;
              ov_nxt = 1'b1;
              ob_nxt = '0;
              oe_nxt = '0;
              os_nxt = arc_pkg::StatusOk;
              oh_nxt = '0;
              ol_nxt = 1'b1;
              on_nxt = 1'b1;
            end
          end else begin
            q_pop = 1'b1;
            if (q_bad) begin
              ov_nxt = 1'b1;
              ob_nxt = '0;
              oe_nxt = '0;
              os_nxt = arc_pkg::StatusBad;
              oh_nxt = 5'(cnt_r);
              ol_nxt = 1'b1;
              on_nxt = 1'b0;
            end
          end
        end
      end
      arc_pkg::BK_INSERT: begin
        if (ofree) begin
          ov_nxt = 1'b1;
          ob_nxt = '0;
          oe_nxt = '0;
          ol_nxt = 1'b1;
          on_nxt = 1'b0;
          os_nxt = arc_pkg::StatusOk;
          if (cov_r) begin
            oh_nxt = 5'(cnt_r);
          end else if (nm == '0 && int'(cnt_r) >= MAX_RANGES) begin
            os_nxt = arc_pkg::StatusFull;
            oh_nxt = 5'(cnt_r);
          end else begin
            // Cells below the gap keep their slot; cells above shift by the merge.
            for (int i = 0; i < MAX_RANGES; i++) begin
              if (i < int'(pos)) begin
                st_nxt[i] = st_r[i];
                en_nxt[i] = en_r[i];
              end else if (i == int'(pos)) begin
                st_nxt[i] = lo;
                en_nxt[i] = hi;
              end else begin
                st_nxt[i] = st_r[IdxW'(i + int'(nm) - 1)];
                en_nxt[i] = en_r[IdxW'(i + int'(nm) - 1)];
              end
            end
            cnt_nxt = CntW'(int'(cnt_r) + 1 - int'(nm));
            oh_nxt = 5'(cnt_nxt);
          end
        end
      end
      arc_pkg::BK_FLUSH: begin
        if (ofree) begin
          ov_nxt = 1'b1;
          ob_nxt = st_r[fidx_r[IdxW-1:0]];
          oe_nxt = en_r[fidx_r[IdxW-1:0]];
          os_nxt = arc_pkg::StatusOk;
          oh_nxt = '0;
          on_nxt = 1'b0;
          ol_nxt = fidx_r + 1'b1 == cnt_r;
          fidx_nxt = fidx_r + 1'b1;
          if (fidx_r + 1'b1 == cnt_r) begin
            q_pop = 1'b1;
            cnt_nxt = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= arc_pkg::BK_IDLE;
      cnt_r <= '0;
      fidx_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      fidx_r <= fidx_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
    en_r <= en_nxt;
    ob_r <= ob_nxt;
    oe_r <= oe_nxt;
    os_r <= os_nxt;
    oh_r <= oh_nxt;
    ol_r <= ol_nxt;
    on_r <= on_nxt;
    tch_r <= tch_c;
    gt_r <= gt_c;
    cov_r <= cov_c;
    f_r <= q_first;
    l_r <= q_last;
  end
endmodule

// ===== rtl/address_range_coalescer_top.sv =====
// Address range coalescer: a sorted table of disjoint inclusive ranges with an
// insert that merges touching ranges and a flush that streams them in order.
// An insert runs through the table logic by first comparing all cells, then
// shifting and writing; a bad range or an empty flush is answered straight
// from the idle state, and a flush of n ranges enters its flush state and then streams
// one range per cycle while the output is taken. A two-entry queue sits
// between command intake and the table, and a result register feeds out.
module address_range_coalescer_top #(
  parameter int MAX_RANGES = arc_pkg::MaxRanges,
  parameter int ADDR_WIDTH = arc_pkg::AddrWidth
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // range_first, range_last
  input  logic         in_tuser,   // cmd
  input  logic         out_tready,
  output logic         out_tvalid,
  output logic [135:0] out_tdata,  // out_begin, out_end, status, ranges_held, pad
  output logic         out_tlast,  // last_of_run
  output logic         out_tuser   // nothing_held
);
  logic                  q_valid, q_pop, q_cmd, q_bad;
  logic [ADDR_WIDTH-1:0] q_first, q_last, ob, oe;
  logic [1:0]            os;
  logic [4:0]            oh;

  arc_front #(.ADDR_WIDTH(ADDR_WIDTH)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_ready(in_tready),
    .in_cmd(in_tuser),
    .in_first(in_tdata[ADDR_WIDTH-1:0]),
    .in_last(in_tdata[64+ADDR_WIDTH-1:64]),
    .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd), .q_bad(q_bad),
    .q_first(q_first), .q_last(q_last)
  );

  arc_back #(.MAX_RANGES(MAX_RANGES), .ADDR_WIDTH(ADDR_WIDTH)) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd), .q_bad(q_bad),
    .q_first(q_first), .q_last(q_last),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .out_begin(ob), .out_end(oe), .out_status(os), .out_held(oh),
    .out_last(out_tlast), .out_none(out_tuser)
  );

  always_comb begin
    out_tdata = '0;
    out_tdata[ADDR_WIDTH-1:0] = ob;
    out_tdata[64+ADDR_WIDTH-1:64] = oe;
    out_tdata[129:128] = os;
    out_tdata[134:130] = oh;
  end
endmodule

// ===== rtl/arc_checker.sv =====
// Port-level checker for the address range coalescer, bound to the top level.
`include "address_range_coalescer_top_macros.svh"
module arc_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [135:0] out_tdata,
  input logic         out_tlast,
  input logic         out_tuser
);
  `ARC_ASSERT_NEXT(a_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `ARC_ASSERT_IMP(a_none_last, out_tvalid && out_tuser, out_tlast)
  `ARC_ASSERT_IMP(a_status, out_tvalid, out_tdata[129:128] <= arc_pkg::StatusBad)
  `ARC_ASSERT_IMP(a_held, out_tvalid, out_tdata[134:130] <= 5'(arc_pkg::MaxRanges))
endmodule

bind address_range_coalescer_top arc_checker u_arc_checker (
  .clk(clk), .rst_n(rst_n), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata), .out_tlast(out_tlast), .out_tuser(out_tuser)
);

// ===== tb/sv/address_range_coalescer_top_tb.sv =====
// Self-checking testbench for the address range coalescer: stream driver, monitor, table predictor.
`timescale 1ns / 100ps
module address_range_coalescer_top_tb;
  localparam int NumItems = 430;
  localparam logic [63:0] TopAddr = '1;

  typedef enum logic {CMD_INSERT = 1'b0, CMD_FLUSH = 1'b1} cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [63:0] first;
    logic [63:0] last;
    bit          drain;  // hold this item back until all results are in
  } cmd_item_t;

  typedef struct packed {
    logic [63:0] rbegin;
    logic [63:0] rend;
    logic [1:0]  status;
    logic [4:0]  held;
    logic        last_of_run;
    logic        none_held;
  } range_result_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;   // range_first, range_last
  logic         in_tuser = 1'b0; // cmd
  logic         out_tready = 1'b0;
  logic         out_tvalid;
  logic [135:0] out_tdata;  // out_begin, out_end, status, ranges_held, pad
  logic         out_tlast;  // last_of_run
  logic         out_tuser;  // nothing_held

  address_range_coalescer_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tready(out_tready), .out_tvalid(out_tvalid), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  cmd_item_t     pending_cmds[$];
  range_result_t expected_results[$];
  cmd_item_t     on_bus;
  int            sent_count = 0;
  int            mismatch_count = 0;
  bit            quiet = 1'b0;

  // Predicted table contents, packed and sorted in slots 0..held-1.
  logic [63:0] tbl_start[arc_pkg::MaxRanges];
  logic [63:0] tbl_end[arc_pkg::MaxRanges];
  int          tbl_held = 0;

  function automatic bit ranges_touch(logic [63:0] s, logic [63:0] e,
                                      logic [63:0] f, logic [63:0] l);
    if (s <= l && f <= e) return 1'b1;
    if (e != TopAddr && e + 64'd1 == f) return 1'b1;
    if (l != TopAddr && l + 64'd1 == s) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic [1:0] merge_range(logic [63:0] f, logic [63:0] l);
    logic [63:0] ns[arc_pkg::MaxRanges];
    logic [63:0] ne[arc_pkg::MaxRanges];
    logic [63:0] lo;
    logic [63:0] hi;
    int n;
    int merged;
    bit placed;
    lo = f;
    hi = l;
    n = 0;
    merged = 0;
    placed = 1'b0;
    if (f > l) return arc_pkg::StatusBad;
    for (int i = 0; i < tbl_held; i++) begin
      if (tbl_start[i] <= f && l <= tbl_end[i]) return arc_pkg::StatusOk;
      if (ranges_touch(tbl_start[i], tbl_end[i], f, l)) begin
        if (tbl_start[i] < lo) lo = tbl_start[i];
        if (tbl_end[i] > hi) hi = tbl_end[i];
        merged++;
      end
    end
    if (merged == 0 && tbl_held >= arc_pkg::MaxRanges) return arc_pkg::StatusFull;
    for (int i = 0; i < tbl_held; i++) begin
      if (ranges_touch(tbl_start[i], tbl_end[i], f, l)) continue;
      if (!placed && tbl_start[i] > hi) begin
        ns[n] = lo;
        ne[n] = hi;
        n++;
        placed = 1'b1;
      end
      ns[n] = tbl_start[i];
      ne[n] = tbl_end[i];
      n++;
    end
    if (!placed) begin
      ns[n] = lo;
      ne[n] = hi;
      n++;
    end
    for (int i = 0; i < n; i++) begin
      tbl_start[i] = ns[i];
      tbl_end[i] = ne[i];
    end
    tbl_held = n;
    return arc_pkg::StatusOk;
  endfunction

  function automatic void predict_results(cmd_item_t it);
    range_result_t r;
    logic [1:0] st;
    if (it.cmd == CMD_INSERT) begin
      st = merge_range(it.first, it.last);
      r = '{64'd0, 64'd0, st, 5'(tbl_held), 1'b1, 1'b0};
      expected_results.insert(expected_results.size(), r);
    end else if (tbl_held == 0) begin
      r = '{64'd0, 64'd0, arc_pkg::StatusOk, 5'd0, 1'b1, 1'b1};
      expected_results.insert(expected_results.size(), r);
    end else begin
      for (int i = 0; i < tbl_held; i++) begin
        r = '{tbl_start[i], tbl_end[i], arc_pkg::StatusOk, 5'd0, (i == tbl_held - 1),
              1'b0};
        expected_results.insert(expected_results.size(), r);
      end
      tbl_held = 0;
    end
  endfunction

  // Sender side.
  int send_gap = 0;
  always @(posedge clk) begin
    cmd_item_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_tuser <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) predict_results(on_bus);
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_tvalid <= 1'b0;
      end else if (pending_cmds.size() > 0 &&
                   !(pending_cmds[0].drain &&
                     (in_tvalid || expected_results.size() != 0))) begin
        nxt = pending_cmds.pop_front();
        on_bus <= nxt;
        in_tvalid <= 1'b1;
        in_tdata <= {nxt.last, nxt.first};
        in_tuser <= nxt.cmd;
        sent_count <= sent_count + 1;
        if (!quiet && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 14);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver side and checking.
  int recv_gap = 0;
  always @(posedge clk) begin
    range_result_t exp_r;
    range_result_t got;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = '{out_tdata[63:0], out_tdata[127:64], out_tdata[129:128],
                out_tdata[134:130], out_tlast, out_tuser};
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result transfer: %p", got);
        end else begin
          exp_r = expected_results.pop_front();
          if (got != exp_r) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: expected %p, got %p", exp_r, got);
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        recv_gap <= $urandom_range(0, 13);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic add_cmd(cmd_t c, logic [63:0] f, logic [63:0] l, bit drain = 1'b0);
    cmd_item_t it;
    it = '{c, f, l, drain};
    pending_cmds.insert(pending_cmds.size(), it);
  endtask

  initial begin
    logic [63:0] base;
    logic [63:0] f;
    int w;
    int stim_total;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty flush, merges, coverage, bad range, top address, full table.
    add_cmd(CMD_FLUSH, 64'd0, 64'd0);
    add_cmd(CMD_INSERT, 64'd0, 64'd0);
    add_cmd(CMD_INSERT, 64'd1, 64'd5);
    add_cmd(CMD_INSERT, 64'd2, 64'd3);
    add_cmd(CMD_INSERT, 64'd10, 64'd5);
    add_cmd(CMD_INSERT, TopAddr - 64'd15, TopAddr);
    add_cmd(CMD_INSERT, TopAddr, 64'd0);
    add_cmd(CMD_INSERT, TopAddr, TopAddr);
    add_cmd(CMD_FLUSH, 64'd0, 64'd0);
    for (int i = 0; i < arc_pkg::MaxRanges; i++)
      add_cmd(CMD_INSERT, 64'(i * 10), 64'(i * 10 + 3));
    add_cmd(CMD_INSERT, 64'd500, 64'd600);
    add_cmd(CMD_INSERT, 64'd4, 64'd9);
    add_cmd(CMD_INSERT, 64'd0, TopAddr);
    add_cmd(CMD_FLUSH, 64'd0, 64'd0, 1'b1);

    // Random: clustered inserts in a random window so ranges merge often; also flushes, bad ranges.
    stim_total = pending_cmds.size();
    base = {$urandom, $urandom};
    while (stim_total < NumItems) begin
      if ($urandom_range(0, 39) == 0) begin
        case ($urandom_range(0, 2))
          0: base = {$urandom, $urandom};
          1: base = TopAddr - 64'd400;
          default: base = 64'd0;
        endcase
      end
      f = base + 64'($urandom_range(0, 400));
      w = $urandom_range(0, 24);
      case ($urandom_range(0, 19))
        0, 1: add_cmd(CMD_FLUSH, {$urandom, $urandom}, {$urandom, $urandom},
                      $urandom_range(0, 5) == 0);
        2: add_cmd(CMD_INSERT, f + 64'd1 + 64'(w), f);
        3: add_cmd(CMD_INSERT, {$urandom, $urandom}, {$urandom, $urandom});
        default: add_cmd(CMD_INSERT, f, (f > TopAddr - 64'(w)) ? TopAddr : f + 64'(w));
      endcase
      stim_total++;
    end
    add_cmd(CMD_FLUSH, 64'd0, 64'd0);

    wait (sent_count >= stim_total - 40);
    quiet = 1'b1;
    wait (pending_cmds.size() == 0 && !in_tvalid && expected_results.size() == 0);
    repeat (50) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule

// ===== address_range_coalescer_top.f =====
+incdir+rtl
rtl/arc_pkg.sv
rtl/arc_front.sv
rtl/arc_back.sv
rtl/address_range_coalescer_top.sv
rtl/arc_checker.sv
tb/sv/address_range_coalescer_top_tb.sv
